>>> design/doc_pkg.sv
// Shared types, constants and fixed-point helpers for the disturbance observer compensator.
// No dependencies; doc_if, doc_mac and the top level refer to this package by scoped names.
`default_nettype none
package doc_pkg;

   localparam int DATA_W = 32;
   localparam int OPND_W = 33;
   localparam int PROD_W = 48;
   localparam int ACC_W  = 56;
   localparam int CSR_IDX_W = 3;
   localparam int COEF_IDX_W = 7;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_Q_ALPHA      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_GAIN_DC  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_MAX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_MIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_MAX      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ORDER = 3'd6;

   localparam logic REQ_STEP  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;
   localparam logic [1:0] ORDER_TWO = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_Y_ISSUE, ST_Y_WAIT, ST_F1_ISSUE, ST_F1_WAIT, ST_F2_ISSUE, ST_F2_WAIT,
      ST_D_ISSUE, ST_D_WAIT, ST_CMD, ST_EMIT, ST_X_ISSUE, ST_X_WAIT
   } doc_state_type;

   // Operand selection for one multiply-accumulate term
   typedef enum logic [2:0] {
      SEL_MEM_MEM, SEL_MEM_LAST, SEL_MEM_U, SEL_ALPHA_F1, SEL_BETA_INNOV,
      SEL_ALPHA_F2, SEL_BETA_F1, SEL_DOUT_GAIN
   } doc_sel_type;

   typedef struct packed {
      logic        valid;
      logic        first;
      logic        last;
      logic        wr;
      doc_sel_type sel;
   } doc_tag_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic acc_first;
   } doc_mac_ctl_type;

   function automatic logic signed [ACC_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
      return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = 56'sh0000007FFFFFFF;
      lo = -56'sh00000080000000;
      if (v > hi) return 32'sh7FFFFFFF;
      if (v < lo) return 32'sh80000000;
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [DATA_W-1:0] v,
                                                       input logic signed [DATA_W-1:0] lo,
                                                       input logic signed [DATA_W-1:0] hi);
      logic signed [DATA_W-1:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/doc_if.sv
// Channel interfaces for the request, result and configuration ports.
// Depends on doc_pkg for field widths.
`default_nettype none
interface doc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic signed [doc_pkg::DATA_W-1:0] error_in;
   logic signed [doc_pkg::DATA_W-1:0] feedback_cmd;
   logic signed [doc_pkg::DATA_W-1:0] meas_out;
   logic                              meas_valid;
   logic [doc_pkg::COEF_IDX_W-1:0]    coef_index;
   logic signed [doc_pkg::DATA_W-1:0] coef_value;
   modport source (output valid, req_type, error_in, feedback_cmd, meas_out, meas_valid,
                   coef_index, coef_value, input ready);
   modport sink (input valid, req_type, error_in, feedback_cmd, meas_out, meas_valid,
                 coef_index, coef_value, output ready);
endinterface

interface doc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [doc_pkg::DATA_W-1:0] command;
   logic signed [doc_pkg::DATA_W-1:0] dist_estimate;
   logic signed [doc_pkg::DATA_W-1:0] nominal_out;
   modport source (output valid, command, dist_estimate, nominal_out, input ready);
   modport sink (input valid, command, dist_estimate, nominal_out, output ready);
endinterface

interface doc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [doc_pkg::CSR_IDX_W-1:0]    index;
   logic [doc_pkg::DATA_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/disturbance_observer_compensator_unit.sv
// Top level of the disturbance observer compensator; sequencer, registers and result slot.
// Depends on doc_pkg, doc_if, doc_store and doc_mac.
`default_nettype none
// Disturbance observer compensator with a one- or two-stage low-pass Q filter, all values
// Q16.16 with saturation. A control transaction (req_type 0) yields one result transaction
// carrying the clamped command, the clamped disturbance estimate and the predicted nominal
// output; a coefficient write transaction (req_type 1) yields no result, and an index beyond
// the coefficient count is dropped. One item is worked at a time: a control step runs on the
// single shared multiplier, which streams one term per cycle from the coefficient and state
// memories behind a three-stage pipeline. The result sits in an output register, so the next
// request is taken while it waits; the step stalls only if a previous result has still not
// been taken when the new one is ready. Model state lives in a two-bank memory: the new
// state is written to the idle bank and the banks swap at the end of the step. Both stores
// read as zero after reset. Configuration writes are always taken and should only be issued
// while idle.
module disturbance_observer_compensator_unit #(
   parameter int MODEL_ORDER = 4
) (
   input wire logic  clock,
   input wire logic  reset,
   doc_req_if.sink   req_chan,
   doc_rsp_if.source rsp_chan,
   doc_csr_if.sink   csr_chan
);
   localparam int N          = MODEL_ORDER;
   localparam int COEF_COUNT = N * N + 2 * N + 1;
   localparam int B_BASE     = N * N;
   localparam int C_BASE     = N * N + N;
   localparam int D_SLOT     = N * N + 2 * N;
   localparam int CW         = $clog2(COEF_COUNT);
   localparam int SD         = 2 * N;
   localparam int SW         = $clog2(SD);
   localparam int KW         = $clog2(N + 1);
   localparam int IW         = (N > 1) ? $clog2(N) : 1;

   typedef logic signed [doc_pkg::DATA_W-1:0] word_type;

   // configuration registers
   logic [16:0] q_alpha_ff;
   word_type    inv_gain_ff, dist_min_ff, dist_max_ff, cmd_min_ff, cmd_max_ff;
   logic [1:0]  order_ff;

   // sequencer
   doc_pkg::doc_state_type state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic [IW-1:0] i_ff, i_in;
   logic          bank_ff, bank_in;

   // step registers
   word_type err_ff, fb_ff, meas_ff;
   logic     mvalid_ff;
   word_type ynom_ff, innov_ff, dout_ff, dhat_ff, u_ff;
   word_type f1_ff, f1_in, f2_ff, f2_in, last_cmd_ff, last_cmd_in;
   word_type ynom_in, innov_in, dout_in, dhat_in, u_in;
   logic     load_y, load_d, load_u;

   // term pipeline
   doc_pkg::doc_tag_type issue_tag, p1_ff, p2_ff, p3_ff;
   logic [SW-1:0] issue_waddr, w1_ff, w2_ff, w3_ff;

   // memories
   logic            coef_we, coef_re, st_re, st_we;
   logic [CW-1:0]   coef_waddr, coef_raddr;
   logic [SW-1:0]   st_raddr;
   word_type        coef_rd, st_rd;
   logic [doc_pkg::DATA_W-1:0] coef_rd_raw, st_rd_raw;

   // multiplier
   doc_pkg::doc_mac_ctl_type mac_ctl;
   logic signed [doc_pkg::OPND_W-1:0] opa, opb;
   logic signed [doc_pkg::ACC_W-1:0]  acc;
   word_type acc_sat;

   // result slot
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_cmd_ff, rsp_dist_ff, rsp_nom_ff;
   logic     rsp_load;

   logic [16:0] alpha_c, beta;
   logic        req_fire, step_done, x_done;
   word_type    y_val;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == doc_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_alpha_ff  <= '0;
         inv_gain_ff <= 32'sd65536;
         dist_min_ff <= 32'sh80000000;
         dist_max_ff <= 32'sh7FFFFFFF;
         cmd_min_ff  <= 32'sh80000000;
         cmd_max_ff  <= 32'sh7FFFFFFF;
         order_ff    <= 2'd1;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            doc_pkg::CSR_Q_ALPHA:      q_alpha_ff  <= csr_chan.data[16:0];
            doc_pkg::CSR_INV_GAIN_DC:  inv_gain_ff <= csr_chan.data;
            doc_pkg::CSR_DIST_MIN:     dist_min_ff <= csr_chan.data;
            doc_pkg::CSR_DIST_MAX:     dist_max_ff <= csr_chan.data;
            doc_pkg::CSR_CMD_MIN:      cmd_min_ff  <= csr_chan.data;
            doc_pkg::CSR_CMD_MAX:      cmd_max_ff  <= csr_chan.data;
            doc_pkg::CSR_FILTER_ORDER: order_ff    <= csr_chan.data[1:0];
            default: ;
         endcase
      end
   end

   // pole above one acts as one
   assign alpha_c = (q_alpha_ff > doc_pkg::ONE_Q16) ? doc_pkg::ONE_Q16 : q_alpha_ff;
   assign beta    = doc_pkg::ONE_Q16 - alpha_c;

   // coefficient and model-state memories
   assign coef_we    = req_fire && (req_chan.req_type == doc_pkg::REQ_WRITE)
                       && (req_chan.coef_index < doc_pkg::COEF_IDX_W'(COEF_COUNT));
   assign coef_waddr = req_chan.coef_index[CW-1:0];

   doc_store #(.WIDTH(doc_pkg::DATA_W), .DEPTH(COEF_COUNT)) u_coef_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_chan.coef_value),
      .rd_en   (coef_re),
      .rd_addr (coef_raddr),
      .rd_data (coef_rd_raw)
   );

   doc_store #(.WIDTH(doc_pkg::DATA_W), .DEPTH(SD)) u_state_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_we),
      .wr_addr (w3_ff),
      .wr_data (acc_sat),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rd_raw)
   );

   assign coef_rd = coef_rd_raw;
   assign st_rd   = st_rd_raw;
   assign acc_sat = doc_pkg::sat32(acc);
   // write a finished state row from the accumulator
   assign st_we   = p3_ff.valid && p3_ff.wr;

   // operand selection for the term now leaving the memories
   always_comb begin
      opa = '0;
      opb = '0;
      case (p1_ff.sel)
         doc_pkg::SEL_MEM_MEM: begin
            opa = {coef_rd[31], coef_rd};
            opb = {st_rd[31], st_rd};
         end
         doc_pkg::SEL_MEM_LAST: begin
            opa = {coef_rd[31], coef_rd};
            opb = {last_cmd_ff[31], last_cmd_ff};
         end
         doc_pkg::SEL_MEM_U: begin
            opa = {coef_rd[31], coef_rd};
            opb = {u_ff[31], u_ff};
         end
         doc_pkg::SEL_ALPHA_F1: begin
            opa = {16'd0, alpha_c};
            opb = {f1_ff[31], f1_ff};
         end
         doc_pkg::SEL_BETA_INNOV: begin
            opa = {16'd0, beta};
            opb = {innov_ff[31], innov_ff};
         end
         doc_pkg::SEL_ALPHA_F2: begin
            opa = {16'd0, alpha_c};
            opb = {f2_ff[31], f2_ff};
         end
         doc_pkg::SEL_BETA_F1: begin
            opa = {16'd0, beta};
            opb = {f1_ff[31], f1_ff};
         end
         doc_pkg::SEL_DOUT_GAIN: begin
            opa = {dout_ff[31], dout_ff};
            opb = {inv_gain_ff[31], inv_gain_ff};
         end
         default: ;
      endcase
   end

   assign mac_ctl.mul_en    = p1_ff.valid;
   assign mac_ctl.acc_en    = p2_ff.valid;
   assign mac_ctl.acc_first = p2_ff.first;

   doc_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .opa   (opa),
      .opb   (opb),
      .acc   (acc)
   );

   // a sum is final when its last term reaches the third stage
   assign step_done = p3_ff.valid && p3_ff.last;
   assign x_done    = step_done && !p2_ff.valid && !p1_ff.valid;

   assign y_val = mvalid_ff ? meas_ff : doc_pkg::sat32(-doc_pkg::ext32(err_ff));

   // sequencer: next state, term issue and step values
   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      bank_in     = bank_ff;
      issue_tag   = '0;
      issue_tag.sel = doc_pkg::SEL_MEM_MEM;
      issue_waddr = '0;
      coef_re     = 1'b0;
      st_re       = 1'b0;
      coef_raddr  = '0;
      st_raddr    = '0;
      load_y      = 1'b0;
      load_d      = 1'b0;
      load_u      = 1'b0;
      rsp_load    = 1'b0;
      f1_in       = f1_ff;
      f2_in       = f2_ff;
      dout_in     = dout_ff;
      last_cmd_in = last_cmd_ff;
      ynom_in     = acc_sat;
      innov_in    = doc_pkg::sat32(doc_pkg::ext32(y_val) - doc_pkg::ext32(acc_sat));
      dhat_in     = doc_pkg::clamp32(acc_sat, dist_min_ff, dist_max_ff);
      u_in        = doc_pkg::clamp32(doc_pkg::sat32(doc_pkg::ext32(fb_ff)
                                                    - doc_pkg::ext32(dhat_ff)),
                                     cmd_min_ff, cmd_max_ff);
      case (state_ff)
         doc_pkg::ST_IDLE: begin
            k_in = '0;
            i_in = '0;
            if (req_fire && (req_chan.req_type == doc_pkg::REQ_STEP)) begin
               state_in = doc_pkg::ST_Y_ISSUE;
            end
         end
         doc_pkg::ST_Y_ISSUE: begin
            // nominal output: C times state, then D times previous command
            coef_re = 1'b1;
            st_re   = 1'b1;
            issue_tag.valid = 1'b1;
            issue_tag.first = (k_ff == '0);
            issue_tag.last  = (k_ff == KW'(N));
            if (k_ff == KW'(N)) begin
               coef_raddr    = CW'(D_SLOT);
               issue_tag.sel = doc_pkg::SEL_MEM_LAST;
               state_in      = doc_pkg::ST_Y_WAIT;
               k_in          = '0;
            end else begin
               coef_raddr    = CW'(C_BASE) + CW'(k_ff);
               st_raddr      = (bank_ff ? SW'(N) : SW'(0)) + SW'(k_ff);
               issue_tag.sel = doc_pkg::SEL_MEM_MEM;
               k_in          = k_ff + 1'b1;
            end
         end
         doc_pkg::ST_Y_WAIT: begin
            if (step_done) begin
               load_y   = 1'b1;
               state_in = doc_pkg::ST_F1_ISSUE;
            end
         end
         doc_pkg::ST_F1_ISSUE: begin
            issue_tag.valid = 1'b1;
            issue_tag.first = (k_ff == '0);
            issue_tag.last  = (k_ff != '0);
            issue_tag.sel   = (k_ff == '0) ? doc_pkg::SEL_ALPHA_F1 : doc_pkg::SEL_BETA_INNOV;
            k_in = k_ff + 1'b1;
            if (k_ff != '0) begin
               k_in     = '0;
               state_in = doc_pkg::ST_F1_WAIT;
            end
         end
         doc_pkg::ST_F1_WAIT: begin
            if (step_done) begin
               f1_in = acc_sat;
               if (order_ff == doc_pkg::ORDER_TWO) begin
                  state_in = doc_pkg::ST_F2_ISSUE;
               end else begin
                  dout_in  = acc_sat;
                  state_in = doc_pkg::ST_D_ISSUE;
               end
            end
         end
         doc_pkg::ST_F2_ISSUE: begin
            issue_tag.valid = 1'b1;
            issue_tag.first = (k_ff == '0);
            issue_tag.last  = (k_ff != '0);
            issue_tag.sel   = (k_ff == '0) ? doc_pkg::SEL_ALPHA_F2 : doc_pkg::SEL_BETA_F1;
            k_in = k_ff + 1'b1;
            if (k_ff != '0) begin
               k_in     = '0;
               state_in = doc_pkg::ST_F2_WAIT;
            end
         end
         doc_pkg::ST_F2_WAIT: begin
            if (step_done) begin
               f2_in    = acc_sat;
               dout_in  = acc_sat;
               state_in = doc_pkg::ST_D_ISSUE;
            end
         end
         doc_pkg::ST_D_ISSUE: begin
            issue_tag.valid = 1'b1;
            issue_tag.first = 1'b1;
            issue_tag.last  = 1'b1;
            issue_tag.sel   = doc_pkg::SEL_DOUT_GAIN;
            state_in        = doc_pkg::ST_D_WAIT;
         end
         doc_pkg::ST_D_WAIT: begin
            if (step_done) begin
               load_d   = 1'b1;
               state_in = doc_pkg::ST_CMD;
            end
         end
         doc_pkg::ST_CMD: begin
            load_u   = 1'b1;
            state_in = doc_pkg::ST_EMIT;
         end
         doc_pkg::ST_EMIT: begin
            // hold until the result slot is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               k_in     = '0;
               i_in     = '0;
               state_in = doc_pkg::ST_X_ISSUE;
            end
         end
         doc_pkg::ST_X_ISSUE: begin
            // state row i: B[i]*u, then A[i][j]*x[j]; written to the idle bank
            coef_re = 1'b1;
            st_re   = 1'b1;
            issue_tag.valid = 1'b1;
            issue_tag.first = (k_ff == '0);
            issue_tag.last  = (k_ff == KW'(N));
            issue_tag.wr    = (k_ff == KW'(N));
            issue_waddr     = (bank_ff ? SW'(0) : SW'(N)) + SW'(i_ff);
            if (k_ff == '0) begin
               coef_raddr    = CW'(B_BASE) + CW'(i_ff);
               issue_tag.sel = doc_pkg::SEL_MEM_U;
            end else begin
               coef_raddr    = CW'(i_ff) * CW'(N) + CW'(k_ff - 1'b1);
               st_raddr      = (bank_ff ? SW'(N) : SW'(0)) + SW'(k_ff - 1'b1);
               issue_tag.sel = doc_pkg::SEL_MEM_MEM;
            end
            if (k_ff == KW'(N)) begin
               k_in = '0;
               i_in = i_ff + 1'b1;
               if (i_ff == IW'(N - 1)) begin
                  i_in     = '0;
                  state_in = doc_pkg::ST_X_WAIT;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         doc_pkg::ST_X_WAIT: begin
            if (x_done) begin
               bank_in     = !bank_ff;
               last_cmd_in = u_ff;
               state_in    = doc_pkg::ST_IDLE;
            end
         end
         default: state_in = doc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= doc_pkg::ST_IDLE;
         k_ff         <= '0;
         i_ff         <= '0;
         bank_ff      <= 1'b0;
         f1_ff        <= '0;
         f2_ff        <= '0;
         last_cmd_ff  <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         bank_ff      <= bank_in;
         f1_ff        <= f1_in;
         f2_ff        <= f2_in;
         last_cmd_ff  <= last_cmd_in;
         p1_ff        <= issue_tag;
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w1_ff   <= issue_waddr;
      w2_ff   <= w1_ff;
      w3_ff   <= w2_ff;
      dout_ff <= dout_in;
      if (req_fire) begin
         err_ff    <= req_chan.error_in;
         fb_ff     <= req_chan.feedback_cmd;
         meas_ff   <= req_chan.meas_out;
         mvalid_ff <= req_chan.meas_valid;
      end
      if (load_y) begin
         ynom_ff  <= ynom_in;
         innov_ff <= innov_in;
      end
      if (load_d) begin
         dhat_ff <= dhat_in;
      end
      if (load_u) begin
         u_ff <= u_in;
      end
      if (rsp_load) begin
         rsp_cmd_ff  <= u_ff;
         rsp_dist_ff <= dhat_ff;
         rsp_nom_ff  <= ynom_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.command       = rsp_cmd_ff;
   assign rsp_chan.dist_estimate = rsp_dist_ff;
   assign rsp_chan.nominal_out   = rsp_nom_ff;

endmodule
`default_nettype wire

>>> design/doc_store.sv
// Synchronous store with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset; no package use.
`default_nettype none
module doc_store #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 25
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> design/doc_mac.sv
// Shared Q16.16 multiply-accumulate unit: registered product, then accumulator.
// Depends on doc_pkg for widths and the control struct.
`default_nettype none
module doc_mac (
   input  wire logic                                clock,
   input  wire doc_pkg::doc_mac_ctl_type            ctl,
   input  wire logic signed [doc_pkg::OPND_W-1:0]   opa,
   input  wire logic signed [doc_pkg::OPND_W-1:0]   opb,
   output logic signed      [doc_pkg::ACC_W-1:0]    acc
);
   logic signed [2*doc_pkg::OPND_W-1:0] full;
   logic signed [2*doc_pkg::OPND_W-1:0] shifted;
   logic signed [doc_pkg::PROD_W-1:0]   prod_ff;
   logic signed [doc_pkg::ACC_W-1:0]    prod_ext;
   logic signed [doc_pkg::ACC_W-1:0]    acc_ff;

   assign full     = opa * opb;
   assign shifted  = full >>> 16;   // floor division by 2^16
   assign prod_ext = {{(doc_pkg::ACC_W-doc_pkg::PROD_W){prod_ff[doc_pkg::PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= shifted[doc_pkg::PROD_W-1:0];
      end
      if (ctl.acc_en) begin
         acc_ff <= ctl.acc_first ? prod_ext : acc_ff + prod_ext;
      end
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire
